// ----- hdl/cpmc_pkg.sv -----
package cpmc_pkg;

	// Default fixed-point format: Q8.8 gains, 8 fraction bits on loop values
	localparam int FRAC_BITS_DEF  = 8;
	localparam int GAIN_WIDTH_DEF = 16;

	// Operand slice width taken by the shared multiplier per step
	localparam int MUL_CHUNK = 32;

	// Fixed field and register widths
	localparam int INTEG_W     = 33;
	localparam int GAIN_REG_W  = 48;
	localparam int LIMIT_REG_W = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int MODE_W      = 2;
	localparam int LOOP_W      = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAINS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMITS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAINS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMITS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAINS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMITS = 3'd6;

	// Loop modes
	localparam logic [MODE_W-1:0] MODE_SPEED         = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ANGLE_SPEED   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPEED_CURRENT = 2'd2;

	// Loop identifiers
	localparam logic [LOOP_W-1:0] LOOP_ANGLE   = 2'd0;
	localparam logic [LOOP_W-1:0] LOOP_SPEED   = 2'd1;
	localparam logic [LOOP_W-1:0] LOOP_CURRENT = 2'd2;

	typedef struct packed {
		logic signed [31:0] target;
		logic signed [31:0] angle_meas;
		logic signed [15:0] speed_meas;
		logic signed [15:0] current_meas;
		logic               clear;
	} tick_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic signed [31:0] outer_output;
		logic               drive_clipped;
	} result_t;

	// Settings of the loop that is running
	typedef struct packed {
		logic [GAIN_REG_W-1:0] gains;
		logic [31:0]           ilim;
		logic [30:0]           olim;
	} loop_cfg_t;

endpackage

// ----- hdl/cpmc_cfg_regs.sv -----
module cpmc_cfg_regs import cpmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic [LOOP_W-1:0]    sel,
	output logic [MODE_W-1:0]    mode,
	output loop_cfg_t            lcfg
);

	logic [MODE_W-1:0]      mode_q;
	logic [GAIN_REG_W-1:0]  gains_q  [3];
	logic [LIMIT_REG_W-1:0] limits_q [3];
	logic [LIMIT_REG_W-1:0] lim_sel;

	// Decode register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SPEED;
			for (int i = 0; i < 3; i++) begin
				gains_q[i]  <= '0;
				limits_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOOP_MODE:      mode_q                <= cfg_data[MODE_W-1:0];
				REG_ANGLE_GAINS:    gains_q[LOOP_ANGLE]   <= cfg_data[GAIN_REG_W-1:0];
				REG_ANGLE_LIMITS:   limits_q[LOOP_ANGLE]  <= cfg_data;
				REG_SPEED_GAINS:    gains_q[LOOP_SPEED]   <= cfg_data[GAIN_REG_W-1:0];
				REG_SPEED_LIMITS:   limits_q[LOOP_SPEED]  <= cfg_data;
				REG_CURRENT_GAINS:  gains_q[LOOP_CURRENT] <= cfg_data[GAIN_REG_W-1:0];
				REG_CURRENT_LIMITS: limits_q[LOOP_CURRENT] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select the running loop's gains and limits
	always_comb begin
		case (sel)
			LOOP_ANGLE: begin
				lcfg.gains = gains_q[LOOP_ANGLE];
				lim_sel    = limits_q[LOOP_ANGLE];
			end
			LOOP_CURRENT: begin
				lcfg.gains = gains_q[LOOP_CURRENT];
				lim_sel    = limits_q[LOOP_CURRENT];
			end
			default: begin
				lcfg.gains = gains_q[LOOP_SPEED];
				lim_sel    = limits_q[LOOP_SPEED];
			end
		endcase
		lcfg.ilim = lim_sel[31:0];
		// Cap the output limit so the clamped output fits 32 bits signed
		lcfg.olim = lim_sel[63] ? 31'h7FFF_FFFF : lim_sel[62:32];
	end

	assign mode = mode_q;

endmodule

// ----- hdl/cpmc_mul.sv -----
module cpmc_mul import cpmc_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int GAIN_WIDTH = GAIN_WIDTH_DEF,
	parameter int OP_W       = INTEG_W + FRAC_BITS_DEF + 1,
	parameter int RES_W      = GAIN_WIDTH_DEF + INTEG_W + 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [GAIN_WIDTH-1:0] gain,
	input  logic signed [OP_W-1:0]  operand,
	output logic                    done,
	output logic signed [RES_W-1:0] result
);

	localparam int NCH    = (OP_W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PADW   = NCH * MUL_CHUNK;
	localparam int PROD_W = GAIN_WIDTH + MUL_CHUNK + 1;
	localparam int PW_A   = GAIN_WIDTH + PADW;
	localparam int PW_B   = RES_W + FRAC_BITS;
	localparam int PW_C   = (PW_A > PW_B) ? PW_A : PW_B;
	localparam int PW     = (PW_C > PROD_W) ? PW_C : PROD_W + 1;
	localparam int CNT_W  = $clog2(NCH + 1);

	logic signed [PADW-1:0]       op_q;
	logic signed [GAIN_WIDTH-1:0] gain_q;
	logic [CNT_W-1:0]             left_q;
	logic                         first_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic                         pv_q;
	logic                         plast_q;
	logic signed [PW-1:0]         acc_q;
	logic                         done_q;
	logic signed [MUL_CHUNK:0]    chunk;
	logic signed [PW-1:0]         shifted;

	// Top slice carries the sign, lower slices are unsigned
	assign chunk = $signed({first_q & op_q[PADW-1], op_q[PADW-1 -: MUL_CHUNK]});

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			pv_q    <= 1'b0;
			plast_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= pv_q & plast_q;
			if (start) begin
				left_q <= CNT_W'(NCH);
				pv_q   <= 1'b0;
			end else if (left_q != '0) begin
				left_q  <= left_q - CNT_W'(1);
				pv_q    <= 1'b1;
				plast_q <= (left_q == CNT_W'(1));
			end else begin
				pv_q <= 1'b0;
			end
		end
	end

	// Multiply one slice, then fold it into the accumulator, top slice first
	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= PADW'(operand);
			gain_q  <= gain;
			first_q <= 1'b1;
			acc_q   <= '0;
		end else begin
			if (left_q != '0) begin
				prod_q  <= gain_q * chunk;
				op_q    <= op_q << MUL_CHUNK;
				first_q <= 1'b0;
			end
			if (pv_q) begin
				acc_q <= (acc_q <<< MUL_CHUNK) + PW'(prod_q);
			end
		end
	end

	// Drop the fraction bits, rounding toward minus infinity
	assign shifted = acc_q >>> FRAC_BITS;
	assign result  = shifted[RES_W-1:0];
	assign done    = done_q;

endmodule

// ----- hdl/cascaded_pid_motor_controller_core.sv -----
// Cascaded positional PID controller. Each tick word runs the speed loop
// alone, angle into speed, or speed into current, as loop_mode selects; loop
// values carry FRAC_BITS fraction bits and gains are signed fixed point of
// GAIN_WIDTH bits. All products go through one shared multiplier that takes a
// 32-bit slice of its operand per cycle, the operand being split into
// N = ceil((FRAC_BITS + 34) / 32) slices. tick_ready is high only between
// ticks. The result word sits in an output register, so the next tick is
// taken while it waits.
module cascaded_pid_motor_controller_core import cpmc_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int GAIN_WIDTH = GAIN_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  tick_t                tick,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	// Error, error difference and term/sum widths
	localparam int EW = INTEG_W + FRAC_BITS;
	localparam int DW = EW + 1;
	localparam int VW = GAIN_WIDTH + INTEG_W + 3;
	localparam int GX = 3 * GAIN_WIDTH + GAIN_REG_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ERR    = 4'd1;
	localparam logic [3:0] S_DIFF   = 4'd2;
	localparam logic [3:0] S_WP     = 4'd3;
	localparam logic [3:0] S_IISS   = 4'd4;
	localparam logic [3:0] S_WI     = 4'd5;
	localparam logic [3:0] S_DISS   = 4'd6;
	localparam logic [3:0] S_WD     = 4'd7;
	localparam logic [3:0] S_OSUM   = 4'd8;
	localparam logic [3:0] S_OCLAMP = 4'd9;
	localparam logic [3:0] S_DRIVE  = 4'd10;
	localparam logic [3:0] S_PUT    = 4'd11;

	logic [3:0]                state_q;
	logic signed [31:0]        tgt_q;
	logic signed [31:0]        ang_q;
	logic signed [15:0]        spd_q;
	logic signed [15:0]        cur_q;
	logic [LOOP_W-1:0]         cur_loop_q;
	logic [LOOP_W-1:0]         next_loop_q;
	logic                      cascade_q;
	logic                      on_inner_q;
	logic signed [EW-1:0]      err_q;
	logic signed [DW-1:0]      diff_q;
	logic signed [VW-1:0]      p_q;
	logic signed [VW-1:0]      pd_q;
	logic signed [VW-1:0]      sum_q;
	logic signed [31:0]        outer_q;
	logic signed [31:0]        inner_q;
	logic signed [INTEG_W-1:0] integ_q    [3];
	logic signed [EW-1:0]      last_err_q [3];
	result_t                   pend_q;
	result_t                   res_q;
	logic                      res_valid_q;

	logic [MODE_W-1:0]             mode;
	loop_cfg_t                     lcfg;
	logic [GX-1:0]                 gext;
	logic signed [GAIN_WIDTH-1:0]  mul_gain;
	logic signed [DW-1:0]          mul_op;
	logic                          mul_start;
	logic                          mul_done;
	logic signed [VW-1:0]          mul_res;
	logic signed [EW-1:0]          meas_sc;
	logic signed [EW-1:0]          loop_tgt;
	logic signed [EW-1:0]          err_nxt;
	logic signed [DW-1:0]          diff_nxt;
	logic signed [INTEG_W-1:0]     integ_cur;
	logic signed [EW-1:0]          last_cur;
	logic signed [VW-1:0]          ilim_v;
	logic signed [VW-1:0]          olim_v;
	logic signed [VW-1:0]          integ_clamp;
	logic signed [VW-1:0]          out_clamp;
	logic signed [32:0]            inner_w;
	logic signed [32:0]            bias;
	logic signed [32:0]            whole;
	logic signed [15:0]            drive_sat;
	logic                          drive_clip;

	cpmc_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sel       (cur_loop_q),
		.mode      (mode),
		.lcfg      (lcfg)
	);

	cpmc_mul #(
		.FRAC_BITS  (FRAC_BITS),
		.GAIN_WIDTH (GAIN_WIDTH),
		.OP_W       (DW),
		.RES_W      (VW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.gain    (mul_gain),
		.operand (mul_op),
		.done    (mul_done),
		.result  (mul_res)
	);

	// Measured value of the running loop, scaled to loop format
	always_comb begin
		case (cur_loop_q)
			LOOP_ANGLE:   meas_sc = EW'(ang_q) <<< FRAC_BITS;
			LOOP_CURRENT: meas_sc = EW'(cur_q) <<< FRAC_BITS;
			default:      meas_sc = EW'(spd_q) <<< FRAC_BITS;
		endcase
	end

	// Inner loop follows the outer output, otherwise the scaled setpoint
	assign loop_tgt  = on_inner_q ? EW'(outer_q) : (EW'(tgt_q) <<< FRAC_BITS);
	assign err_nxt   = loop_tgt - meas_sc;
	assign integ_cur = integ_q[cur_loop_q];
	assign last_cur  = last_err_q[cur_loop_q];
	assign diff_nxt  = DW'(err_q) - DW'(last_cur);

	// Gains: bits past the register read as zero
	assign gext = {{(3 * GAIN_WIDTH){1'b0}}, lcfg.gains};

	always_comb begin
		case (state_q)
			S_IISS:  mul_gain = $signed(gext[GAIN_WIDTH +: GAIN_WIDTH]);
			S_DISS:  mul_gain = $signed(gext[2 * GAIN_WIDTH +: GAIN_WIDTH]);
			default: mul_gain = $signed(gext[0 +: GAIN_WIDTH]);
		endcase
	end

	assign mul_op    = (state_q == S_DISS) ? diff_q : DW'(err_q);
	assign mul_start = (state_q == S_DIFF) || (state_q == S_IISS) || (state_q == S_DISS);

	// Symmetric clamps
	assign ilim_v = $signed(VW'(lcfg.ilim));
	assign olim_v = $signed(VW'(lcfg.olim));

	always_comb begin
		if (sum_q > ilim_v) begin
			integ_clamp = ilim_v;
		end else if (sum_q < -ilim_v) begin
			integ_clamp = -ilim_v;
		end else begin
			integ_clamp = sum_q;
		end
		if (sum_q > olim_v) begin
			out_clamp = olim_v;
		end else if (sum_q < -olim_v) begin
			out_clamp = -olim_v;
		end else begin
			out_clamp = sum_q;
		end
	end

	// Truncate toward zero, then saturate to 16 bits
	assign inner_w = 33'(inner_q);
	assign bias    = inner_q[31] ? ((33'sd1 <<< FRAC_BITS) - 33'sd1) : 33'sd0;
	assign whole   = (inner_w + bias) >>> FRAC_BITS;

	always_comb begin
		if (whole > 33'sd32767) begin
			drive_sat  = 16'sh7FFF;
			drive_clip = 1'b1;
		end else if (whole < -33'sd32768) begin
			drive_sat  = -16'sh8000;
			drive_clip = 1'b1;
		end else begin
			drive_sat  = whole[15:0];
			drive_clip = 1'b0;
		end
	end

	// Sequencer and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			cur_loop_q  <= LOOP_SPEED;
			next_loop_q <= LOOP_SPEED;
			cascade_q   <= 1'b0;
			on_inner_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				integ_q[i]    <= '0;
				last_err_q[i] <= '0;
			end
		end else begin
			// Raise result valid when a word lands, drop it once taken
			if (state_q == S_PUT && (!res_valid_q || result_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tick_valid) begin
						on_inner_q <= 1'b0;
						if (tick.clear) begin
							for (int i = 0; i < 3; i++) begin
								integ_q[i]    <= '0;
								last_err_q[i] <= '0;
							end
							state_q <= S_PUT;
						end else begin
							case (mode)
								MODE_ANGLE_SPEED: begin
									cur_loop_q  <= LOOP_ANGLE;
									next_loop_q <= LOOP_SPEED;
									cascade_q   <= 1'b1;
								end
								MODE_SPEED_CURRENT: begin
									cur_loop_q  <= LOOP_SPEED;
									next_loop_q <= LOOP_CURRENT;
									cascade_q   <= 1'b1;
								end
								default: begin
									cur_loop_q  <= LOOP_SPEED;
									next_loop_q <= LOOP_SPEED;
									cascade_q   <= 1'b0;
								end
							endcase
							state_q <= S_ERR;
						end
					end
				end
				S_ERR:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_WP;
				S_WP: begin
					if (mul_done) begin
						state_q <= S_IISS;
					end
				end
				S_IISS: state_q <= S_WI;
				S_WI: begin
					if (mul_done) begin
						state_q <= S_DISS;
					end
				end
				S_DISS: begin
					integ_q[cur_loop_q] <= integ_clamp[INTEG_W-1:0];
					state_q             <= S_WD;
				end
				S_WD: begin
					if (mul_done) begin
						state_q <= S_OSUM;
					end
				end
				S_OSUM: state_q <= S_OCLAMP;
				S_OCLAMP: begin
					last_err_q[cur_loop_q] <= err_q;
					if (cascade_q && !on_inner_q) begin
						cur_loop_q <= next_loop_q;
						on_inner_q <= 1'b1;
						state_q    <= S_ERR;
					end else begin
						state_q <= S_DRIVE;
					end
				end
				S_DRIVE: state_q <= S_PUT;
				S_PUT: begin
					if (!res_valid_q || result_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (tick_valid) begin
					tgt_q   <= tick.target;
					ang_q   <= tick.angle_meas;
					spd_q   <= tick.speed_meas;
					cur_q   <= tick.current_meas;
					outer_q <= '0;
					pend_q  <= '0;
				end
			end
			S_ERR:  err_q  <= err_nxt;
			S_DIFF: diff_q <= diff_nxt;
			S_WP: begin
				if (mul_done) begin
					p_q <= mul_res;
				end
			end
			S_WI: begin
				if (mul_done) begin
					sum_q <= VW'(integ_cur) + mul_res;
				end
			end
			S_WD: begin
				if (mul_done) begin
					pd_q <= p_q + mul_res;
				end
			end
			S_OSUM: sum_q <= pd_q + VW'(integ_cur);
			S_OCLAMP: begin
				if (cascade_q && !on_inner_q) begin
					outer_q <= out_clamp[31:0];
				end else begin
					inner_q <= out_clamp[31:0];
				end
			end
			S_DRIVE: begin
				pend_q.drive         <= drive_sat;
				pend_q.outer_output  <= outer_q;
				pend_q.drive_clipped <= drive_clip;
			end
			S_PUT: begin
				if (!res_valid_q || result_ready) begin
					res_q <= pend_q;
				end
			end
			default: ;
		endcase
	end

	assign tick_ready   = (state_q == S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// The shared multiplier only finishes while the sequencer waits for it
	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WP || state_q == S_WI || state_q == S_WD))
		else $error("multiplier done outside a wait state");

	// A clear word wipes every loop's integral and last error
	a_clear_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready && tick.clear) |=>
		(integ_q[0] == '0 && integ_q[1] == '0 && integ_q[2] == '0 &&
		 last_err_q[0] == '0 && last_err_q[1] == '0 && last_err_q[2] == '0))
		else $error("clear word left loop state behind");

	// A finished word lands in the output register and frees the input side
	a_put_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT && (!result_valid || result_ready)) |=>
		(result_valid && tick_ready))
		else $error("finished word not delivered");

endmodule

// ----- tb/sv/cascaded_pid_motor_controller_core_test.sv -----
module cascaded_pid_motor_controller_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cpmc_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int GW = GAIN_WIDTH_DEF;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int HOLD_SPAN = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_CAP = 200;
	localparam longint TERM_LIM = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
	localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
	localparam result_t IDLE_WORD = '0;

	typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0] data;
		tick_t t;
		result_t known;
	} plan_row_t;

	typedef struct {
		longint integ;
		longint last_err;
	} pid_mem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_ready;
	tick_t tick = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Controller image: registers and per-loop memory
	logic [MODE_W-1:0] mode_now = MODE_SPEED;
	logic [63:0] gains_now [3] = '{default: '0};
	logic [63:0] limits_now [3] = '{default: '0};
	pid_mem_t pid_mem [3] = '{default: '{0, 0}};

	result_t pending_words[$];
	int failures = 0;
	bit quiet = 1'b0;
	logic hold_req = 1'b0;
	int hold_count = 0;
	int ready_wait = 0;

	cascaded_pid_motor_controller_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick         (tick),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int idle_cycles();
		if (quiet || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	// floor(a * g / 2^FRAC), saturated to the term range
	function automatic longint scaled_product(input longint a, input longint g);
		logic signed [127:0] prod;
		prod = a;
		prod = prod * g;
		prod = prod >>> FRAC;
		if (prod > TERM_LIM)
			return TERM_LIM;
		if (prod < -TERM_LIM)
			return -TERM_LIM;
		return longint'(prod);
	endfunction

	function automatic longint gain_at(input logic [63:0] bank, input int k);
		logic signed [GW-1:0] g;
		g = bank[k*GW +: GW];
		return g;
	endfunction

	function automatic longint clamp_sym(input longint x, input longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	// One positional PID pass; updates that loop's integral and last error
	function automatic longint run_pid(input logic [LOOP_W-1:0] n, input longint goal,
			input longint meas);
		longint err, p, d, ilim, olim;
		err = goal - meas;
		ilim = limits_now[n][31:0];
		olim = limits_now[n][63:32];
		if (olim > 64'h7FFF_FFFF)
			olim = 64'h7FFF_FFFF;
		p = scaled_product(err, gain_at(gains_now[n], 0));
		d = scaled_product(err - pid_mem[n].last_err, gain_at(gains_now[n], 2));
		pid_mem[n].integ = clamp_sym(pid_mem[n].integ +
			scaled_product(err, gain_at(gains_now[n], 1)), ilim);
		pid_mem[n].last_err = err;
		return clamp_sym(p + pid_mem[n].integ + d, olim);
	endfunction

	function automatic result_t predict_word(input tick_t t);
		result_t w;
		longint goal, outer, inner, mag, whole;
		w = '0;
		if (t.clear) begin
			for (int n = 0; n < 3; n++)
				pid_mem[n] = '{0, 0};
			return w;
		end
		goal = longint'(t.target) <<< FRAC;
		outer = 0;
		case (mode_now)
			MODE_ANGLE_SPEED: begin
				outer = run_pid(LOOP_ANGLE, goal, longint'(t.angle_meas) <<< FRAC);
				inner = run_pid(LOOP_SPEED, outer, longint'(t.speed_meas) <<< FRAC);
			end
			MODE_SPEED_CURRENT: begin
				outer = run_pid(LOOP_SPEED, goal, longint'(t.speed_meas) <<< FRAC);
				inner = run_pid(LOOP_CURRENT, outer, longint'(t.current_meas) <<< FRAC);
			end
			default: begin
				inner = run_pid(LOOP_SPEED, goal, longint'(t.speed_meas) <<< FRAC);
			end
		endcase
		// Truncate toward zero, then saturate to int16
		mag = (inner < 0) ? -inner : inner;
		mag = mag >>> FRAC;
		whole = (inner < 0) ? -mag : mag;
		if (whole > 32767) begin
			whole = 32767;
			w.drive_clipped = 1'b1;
		end else if (whole < -32768) begin
			whole = -32768;
			w.drive_clipped = 1'b1;
		end
		w.drive = 16'(whole);
		w.outer_output = 32'(outer);
		return w;
	endfunction

	function automatic tick_t make_tick(input int tg, input int ang, input int spd,
			input int cur, input bit clr);
		tick_t t;
		t.target = tg;
		t.angle_meas = ang;
		t.speed_meas = 16'(spd);
		t.current_meas = 16'(cur);
		t.clear = clr;
		return t;
	endfunction

	function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [63:0] data);
		plan_row_t r;
		r = '{ROW_WRITE, idx, data, '0, '0};
		return r;
	endfunction

	function automatic plan_row_t tick_row(input tick_t t);
		plan_row_t r;
		r = '{ROW_TICK, '0, '0, t, '0};
		return r;
	endfunction

	function automatic plan_row_t known_row(input tick_t t, input result_t w);
		plan_row_t r;
		r = '{ROW_KNOWN, '0, '0, t, w};
		return r;
	endfunction

	function automatic logic [15:0] random_gain();
		int v;
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom());
			default: begin
				v = $urandom_range(0, 1200);
				v = v - 600;
				return 16'(v);
			end
		endcase
	endfunction

	function automatic logic [31:0] random_limit();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			3: return 32'h7FFF_FFFF;
			default: return $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	function automatic logic [63:0] pick_gains(input int ph);
		if (ph == 0)
			return {16'($urandom()), 16'h7FFF, 16'h7FFF, 16'h7FFF};
		if (ph == 1)
			return {16'($urandom()), 16'h8000, 16'h8000, 16'h8000};
		return {16'($urandom()), random_gain(), random_gain(), random_gain()};
	endfunction

	function automatic logic [63:0] pick_limits(input int ph);
		if (ph == 0)
			return '1;
		if (ph == 1)
			return {32'h7FFF_FFFF, 32'h0000_0000};
		return {random_limit(), random_limit()};
	endfunction

	// Mostly tracking ticks near the setpoint, some full-range and some clears
	function automatic tick_t random_tick();
		tick_t t;
		int v;
		case ($urandom_range(0, 9))
			0: begin
				t.target = $urandom();
				t.angle_meas = $urandom();
				t.speed_meas = 16'($urandom());
				t.current_meas = 16'($urandom());
			end
			1: begin
				t.target = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				t.angle_meas = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				t.speed_meas = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				t.current_meas = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			end
			default: begin
				v = $urandom_range(0, 4000);
				t.target = v - 2000;
				v = $urandom_range(0, 400);
				t.angle_meas = t.target + v - 200;
				v = $urandom_range(0, 600);
				t.speed_meas = 16'(v - 300);
				v = $urandom_range(0, 600);
				t.current_meas = 16'(v - 300);
			end
		endcase
		t.clear = ($urandom_range(0, 29) == 0);
		return t;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LOOP_MODE: mode_now = data[MODE_W-1:0];
			REG_ANGLE_GAINS: gains_now[LOOP_ANGLE] = {16'd0, data[47:0]};
			REG_ANGLE_LIMITS: limits_now[LOOP_ANGLE] = data;
			REG_SPEED_GAINS: gains_now[LOOP_SPEED] = {16'd0, data[47:0]};
			REG_SPEED_LIMITS: limits_now[LOOP_SPEED] = data;
			REG_CURRENT_GAINS: gains_now[LOOP_CURRENT] = {16'd0, data[47:0]};
			REG_CURRENT_LIMITS: limits_now[LOOP_CURRENT] = data;
			default: ;
		endcase
	endtask

	task automatic load_settings(input int ph);
		logic [MODE_W-1:0] mode;
		mode = (ph < 4) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 3));
		write_reg(REG_LOOP_MODE, {32'($urandom()), 30'd0, mode});
		write_reg(REG_ANGLE_GAINS, pick_gains(ph));
		write_reg(REG_ANGLE_LIMITS, pick_limits(ph));
		write_reg(REG_SPEED_GAINS, pick_gains(ph));
		write_reg(REG_SPEED_LIMITS, pick_limits(ph));
		write_reg(REG_CURRENT_GAINS, pick_gains(ph));
		write_reg(REG_CURRENT_LIMITS, pick_limits(ph));
	endtask

	// Offer one tick word; hold it until taken, then predict its result
	task automatic send_tick(input tick_t t, input bit known, input result_t known_word);
		int gap;
		result_t w;
		gap = idle_cycles();
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick <= t;
		tick_valid <= 1'b1;
		do
			@(posedge clk);
		while (!tick_ready);
		w = predict_word(t);
		pending_words.push_back(known ? known_word : w);
	endtask

	// Drop valid and wait until every predicted result word is back
	task automatic drain_block();
		tick_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_word(input result_t got);
		result_t want;
		if (pending_words.size() == 0) begin
			failures++;
			if (failures <= REPORT_CAP)
				$display("%0t: result word with none expected: %h", $time, got);
			return;
		end
		want = pending_words.pop_front();
		if (got.drive !== want.drive) begin
			failures++;
			if (failures <= REPORT_CAP)
				$display("%0t: drive expected %0d got %0d", $time, want.drive, got.drive);
		end
		if (got.outer_output !== want.outer_output) begin
			failures++;
			if (failures <= REPORT_CAP)
				$display("%0t: outer_output expected %0d got %0d", $time,
					want.outer_output, got.outer_output);
		end
		if (got.drive_clipped !== want.drive_clipped) begin
			failures++;
			if (failures <= REPORT_CAP)
				$display("%0t: drive_clipped expected %0b got %0b", $time,
					want.drive_clipped, got.drive_clipped);
		end
	endtask

	// Result side: check each taken word, then stall at random or for the long hold
	always @(posedge clk) begin : result_sink
		bit take;
		int gap;
		take = result_valid && result_ready;
		if (take)
			check_word(result);
		if (hold_req && hold_count < HOLD_SPAN) begin
			hold_count <= hold_count + 1;
			result_ready <= 1'b0;
		end else if (take) begin
			gap = idle_cycles();
			ready_wait <= gap;
			result_ready <= (gap == 0);
		end else if (ready_wait > 0) begin
			ready_wait <= ready_wait - 1;
			result_ready <= (ready_wait == 1);
		end else begin
			result_ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan[$];
		// Reset state: zero gains and limits give zero everywhere
		plan.push_back(known_row(make_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32767, 32767, 0),
			IDLE_WORD));
		plan.push_back(known_row(make_tick(32'h8000_0000, 32'h8000_0000, -32768, -32768, 0),
			IDLE_WORD));
		plan.push_back(known_row(make_tick(-1, -1, -1, -1, 1), IDLE_WORD));
		// Full proportional gain with an oversized output limit: drive saturates
		plan.push_back(write_row(REG_SPEED_GAINS, 64'h0000_0000_0000_7FFF));
		plan.push_back(write_row(REG_SPEED_LIMITS, 64'hFFFF_FFFF_0000_0000));
		plan.push_back(known_row(make_tick(32767, 0, -32768, 0, 0),
			'{16'sh7FFF, 32'sh0, 1'b1}));
		plan.push_back(known_row(make_tick(-32768, 0, 32767, 0, 0),
			'{16'sh8000, 32'sh0, 1'b1}));
		plan.push_back(known_row(make_tick(0, 0, 0, 0, 0), IDLE_WORD));
		// Unused mode code falls back to the speed loop
		plan.push_back(write_row(REG_LOOP_MODE, {62'd0, MODE_RESERVED}));
		plan.push_back(tick_row(make_tick(100, 5, 0, 0, 0)));
		plan.push_back(tick_row(make_tick(-3, 0, 0, 0, 0)));
		// Angle into speed
		plan.push_back(write_row(REG_ANGLE_GAINS, 64'hFFFF_0080_0040_0100));
		plan.push_back(write_row(REG_ANGLE_LIMITS, 64'h0100_0000_0000_1000));
		plan.push_back(write_row(REG_SPEED_GAINS, 64'h0000_8000_FF80_0200));
		plan.push_back(write_row(REG_SPEED_LIMITS, 64'h7FFF_FFFF_0000_8000));
		plan.push_back(write_row(REG_LOOP_MODE, {62'd0, MODE_ANGLE_SPEED}));
		plan.push_back(tick_row(make_tick(1000, 0, 0, 0, 0)));
		plan.push_back(tick_row(make_tick(1000, 400, 20, 0, 0)));
		plan.push_back(tick_row(make_tick(1000, 900, -5, 0, 0)));
		plan.push_back(tick_row(make_tick(32'h7FFF_FFFF, 32'h8000_0000, 100, 0, 0)));
		plan.push_back(tick_row(make_tick(32'h8000_0000, 32'h7FFF_FFFF, -32768, 0, 0)));
		// Speed into current; integral builds over repeated ticks
		plan.push_back(write_row(REG_CURRENT_GAINS, 64'hA5A5_7FFF_8000_0001));
		plan.push_back(write_row(REG_CURRENT_LIMITS, 64'h8000_0000_FFFF_FFFF));
		plan.push_back(write_row(REG_LOOP_MODE, {62'd0, MODE_SPEED_CURRENT}));
		plan.push_back(tick_row(make_tick(50, 0, 10, -20, 0)));
		plan.push_back(tick_row(make_tick(50, 0, 10, -20, 0)));
		plan.push_back(tick_row(make_tick(50, 0, 10, -20, 0)));
		plan.push_back(known_row(make_tick(77, 1, 2, 3, 1), IDLE_WORD));
		plan.push_back(tick_row(make_tick(-50, 0, -10, 32767, 0)));
		plan.push_back(write_row(CFG_IDX_SPARE, '1));
		plan.push_back(tick_row(make_tick(-50, 0, -10, -32768, 0)));
		plan.push_back(write_row(REG_CURRENT_LIMITS, 64'h0));
		plan.push_back(tick_row(make_tick(20000, 0, -20000, 0, 0)));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				drain_block();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_tick(plan[i].t, plan[i].kind == ROW_KNOWN, plan[i].known);
			end
		end

		// Random phases, each under fresh settings
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_block();
			load_settings(ph);
			quiet = (ph == 2 || ph == 6);
			if (ph == 3)
				hold_req <= 1'b1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 5 && k == ITEMS_PER_PHASE / 2)
					drain_block();
				send_tick(random_tick(), 1'b0, IDLE_WORD);
			end
		end

		drain_block();
		repeat (END_CYCLES) @(posedge clk);
		if (failures == 0 && pending_words.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
